[design/flow_tuple_id_table_unit_macros.svh]
// Assertion macros for the flow tuple id table.
// Included by the checker; depends on nothing else.
`ifndef FLOW_TUPLE_ID_TABLE_UNIT_MACROS_SVH
`define FLOW_TUPLE_ID_TABLE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FTID_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("flow table check failed");

// Consequent must hold in the cycle after the antecedent.
`define FTID_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("flow table check failed");

`endif

[design/ftid_pkg.sv]
// Shared types and constants of the flow tuple id table.
// No dependencies; imported by every module of the block but ftid_ram.
package ftid_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int ID_LIMIT_W      = 7;
    localparam int FLOW_ID_W       = 6;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ID_LIMIT_W-1:0] ID_LIMIT_RST = 7'd64;

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_NEW   = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [15:0] src_family;
        logic [63:0] src_addr_hi;
        logic [63:0] src_addr_lo;
        logic [15:0] src_port;
        logic [15:0] dst_family;
        logic [63:0] dst_addr_hi;
        logic [63:0] dst_addr_lo;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
    } t_req;

    typedef struct packed {
        logic [FLOW_ID_W-1:0] flow_id;
        t_status              status;
    } t_resp;

    // One stored table entry: the full key in compare order.
    typedef struct packed {
        logic [15:0] src_family;
        logic [15:0] dst_family;
        logic [7:0]  protocol;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [63:0] src_addr_hi;
        logic [63:0] src_addr_lo;
        logic [63:0] dst_addr_hi;
        logic [63:0] dst_addr_lo;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // A classified word on its way from the front to the back.
    typedef struct packed {
        t_entry entry;
        logic   empty;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_SCAN   = 2'd1,
        BK_DECIDE = 2'd2
    } t_back_state;

endpackage

[design/flow_tuple_id_table_unit.sv]
// Top level of the exact-match flow table: front stage, word queue, scan back end.
// Depends on ftid_pkg, ftid_front, ftid_queue, ftid_back and ftid_ram.
//
//   Channel   Direction  Handshake               Word
//   in        input      i_in_valid/o_in_ready   ftid_pkg::t_req
//   out       output     o_out_valid/i_out_ready ftid_pkg::t_resp
//   cfg       input      i_cfg_we                flow id limit, 7 bits
//
// With n entries stored, a word that hits entry k stops the scan at entry k and a miss scans
// all n; with the table empty or an empty address in the key the scan is skipped.
// The scan reads the entry RAM one entry per cycle.
// Reset is synchronous and empties the table at once; there is no clearing pass.
// The back end starts a new word only once the result register is empty; the front
// stage and the two-word queue keep accepting words meanwhile.
module flow_tuple_id_table_unit #(
    parameter int TABLE_DEPTH = ftid_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  ftid_pkg::t_req                  i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output ftid_pkg::t_resp                 o_out_data,
    input  logic                            i_cfg_we,
    input  logic [ftid_pkg::ID_LIMIT_W-1:0] i_cfg_wdata
);
    import ftid_pkg::*;

    logic fq_valid, fq_ready;
    t_job fq_data;
    logic qb_valid, qb_pop;
    t_job qb_data;

    ftid_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q_valid  (fq_valid),
        .i_q_ready  (fq_ready),
        .o_q_data   (fq_data)
    );

    ftid_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_data  (fq_data),
        .o_pop_valid  (qb_valid),
        .i_pop        (qb_pop),
        .o_pop_data   (qb_data)
    );

    ftid_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (qb_valid),
        .i_q_data    (qb_data),
        .o_q_pop     (qb_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[design/ftid_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module ftid_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/ftid_front.sv]
// Front stage: takes request words, repacks the key and flags empty addresses.
// Depends on ftid_pkg.
module ftid_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ftid_pkg::t_req i_in_data,
    output logic          o_q_valid,
    input  logic          i_q_ready,
    output ftid_pkg::t_job o_q_data
);
    import ftid_pkg::*;

    logic r_valid, n_valid;
    t_job r_job, n_job;
    logic in_acc;

    assign o_in_ready = !r_valid || i_q_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_valid = r_valid && !i_q_ready;
        n_job   = r_job;
        if (in_acc) begin
            n_valid                 = 1'b1;
            n_job.entry.src_family  = i_in_data.src_family;
            n_job.entry.dst_family  = i_in_data.dst_family;
            n_job.entry.protocol    = i_in_data.protocol;
            n_job.entry.src_port    = i_in_data.src_port;
            n_job.entry.dst_port    = i_in_data.dst_port;
            n_job.entry.src_addr_hi = i_in_data.src_addr_hi;
            n_job.entry.src_addr_lo = i_in_data.src_addr_lo;
            n_job.entry.dst_addr_hi = i_in_data.dst_addr_hi;
            n_job.entry.dst_addr_lo = i_in_data.dst_addr_lo;
            // A key with an empty address can never match, so it skips the scan.
            n_job.empty = (i_in_data.src_family == 16'd0) ||
                          (i_in_data.dst_family == 16'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    assign o_q_valid = r_valid;
    assign o_q_data  = r_job;

endmodule

[design/ftid_queue.sv]
// Short queue of classified words between the front and the back.
// Depends on ftid_pkg.
module ftid_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  ftid_pkg::t_job i_push_data,
    output logic          o_pop_valid,
    input  logic          i_pop,
    output ftid_pkg::t_job o_pop_data
);
    import ftid_pkg::*;

    t_job                   r_slots [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count,  n_count;
    logic                   push, pop;

    assign o_push_ready = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slots[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data = r_slots[r_rd_ptr];

endmodule

[design/ftid_back.sv]
// Back end: scans the entry RAM one entry a cycle, then reports the hit, or inserts or reports full.
// Depends on ftid_pkg and ftid_ram.
module ftid_back #(
    parameter int TABLE_DEPTH = ftid_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  ftid_pkg::t_job                     i_q_data,
    output logic                               o_q_pop,
    input  logic                               i_cfg_we,
    input  logic [ftid_pkg::ID_LIMIT_W-1:0]    i_cfg_wdata,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output ftid_pkg::t_resp                    o_out_data
);
    import ftid_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = (CW > ID_LIMIT_W) ? CW : ID_LIMIT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    t_back_state           r_state, n_state;
    t_entry                r_key, n_key;
    logic [CW-1:0]         r_idx, n_idx;
    logic                  r_pend, n_pend;
    logic [AW-1:0]         r_cmp_idx, n_cmp_idx;
    logic [CW-1:0]         r_count, n_count;
    logic [ID_LIMIT_W-1:0] r_id_limit;
    logic                  r_out_valid, n_out_valid;
    t_resp                 r_out, n_out;

    logic                  rd_en, wr_en;
    logic [AW-1:0]         rd_addr, wr_addr;
    t_entry                rd_data;
    logic                  hit, at_end, full;

    ftid_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_key),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // The read data belongs to the entry issued in the previous cycle.
    assign hit    = r_pend && (rd_data == r_key);
    assign at_end = (r_idx == r_count);
    assign full   = (LW'(r_count) >= LW'(r_id_limit)) || (r_count == DEPTH_C);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid && !r_out_valid) begin
                    n_state = (i_q_data.empty || (r_count == '0)) ? BK_DECIDE : BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (hit) begin
                    n_state = BK_IDLE;
                end else if (at_end) begin
                    n_state = BK_DECIDE;
                end
            end
            BK_DECIDE: begin
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_q_pop     = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_idx[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_count[AW-1:0];
        n_key       = r_key;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_cmp_idx   = r_cmp_idx;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid && !r_out_valid) begin
                    o_q_pop = 1'b1;
                    n_key   = i_q_data.entry;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                end
            end
            BK_SCAN: begin
                if (hit) begin
                    n_pend        = 1'b0;
                    n_out_valid   = 1'b1;
                    n_out.flow_id = FLOW_ID_W'(r_cmp_idx);
                    n_out.status  = ST_FOUND;
                end else if (at_end) begin
                    n_pend = 1'b0;
                end else begin
                    rd_en     = 1'b1;
                    n_cmp_idx = r_idx[AW-1:0];
                    n_idx     = r_idx + 1'b1;
                    n_pend    = 1'b1;
                end
            end
            BK_DECIDE: begin
                n_out_valid = 1'b1;
                if (full) begin
                    n_out.flow_id = '0;
                    n_out.status  = ST_FULL;
                end else begin
                    wr_en         = 1'b1;
                    n_count       = r_count + 1'b1;
                    n_out.flow_id = FLOW_ID_W'(r_count);
                    n_out.status  = ST_NEW;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_id_limit  <= ID_LIMIT_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_id_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[design/ftid_checker.sv]
// Port-level checks of the flow table, bound to the top level.
// Depends on ftid_pkg and flow_tuple_id_table_unit_macros.svh.
`include "flow_tuple_id_table_unit_macros.svh"

module ftid_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input ftid_pkg::t_req  i_in_data,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input ftid_pkg::t_resp o_out_data
);
    import ftid_pkg::*;

    logic [3:0]           r_outstanding, n_outstanding;
    logic [FLOW_ID_W-1:0] r_new_cnt, n_new_cnt;
    logic                 in_acc, out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // Words accepted but not yet answered, and ids handed out so far.
    always_comb begin
        n_outstanding = r_outstanding + 4'(in_acc) - 4'(out_acc);
        n_new_cnt     = (out_acc && (o_out_data.status == ST_NEW)) ? r_new_cnt + 1'b1
                                                                   : r_new_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
            r_new_cnt     <= '0;
        end else begin
            r_outstanding <= n_outstanding;
            r_new_cnt     <= n_new_cnt;
        end
    end

    `FTID_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))
    `FTID_ASSERT_NOW(a_full_zero_id, i_clk, i_rst_n, o_out_valid && (o_out_data.status == ST_FULL), o_out_data.flow_id == '0)
    `FTID_ASSERT_NOW(a_new_id_order, i_clk, i_rst_n, o_out_valid && (o_out_data.status == ST_NEW), o_out_data.flow_id == r_new_cnt)
    `FTID_ASSERT_NOW(a_no_spurious, i_clk, i_rst_n, o_out_valid, r_outstanding != '0)

endmodule

bind flow_tuple_id_table_unit ftid_checker u_ftid_checker (.*);

[test/tb_flow_tuple_id_table_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for flow_tuple_id_table_unit: lookup and insert of flow keys.
// Depends on ftid_pkg and the RTL of the block; a scoreboard class predicts every response.
module tb_flow_tuple_id_table_unit;
    import ftid_pkg::*;

    // Tracks the table contents and the limit, and holds the responses still awaited.
    class flow_table_tracker;
        t_req        slots[TABLE_DEPTH_DEF];
        int unsigned used_slots;
        int unsigned limit;
        t_resp       awaited[$];
        int unsigned failures;

        function new();
            used_slots = 0;
            limit      = 64;
            failures   = 0;
        endfunction

        function void set_limit(int unsigned v);
            limit = v;
        endfunction

        function void note_request(t_req r);
            t_resp exp;
            bit    hit;
            hit = 1'b0;
            // A key with an empty address on either side never matches anything.
            if (r.src_family != 16'd0 && r.dst_family != 16'd0) begin
                for (int i = 0; i < used_slots && !hit; i++) begin
                    if (slots[i] == r) begin
                        hit          = 1'b1;
                        exp.flow_id  = FLOW_ID_W'(i);
                        exp.status   = ST_FOUND;
                    end
                end
            end
            if (!hit) begin
                if (used_slots >= limit || used_slots >= TABLE_DEPTH_DEF) begin
                    exp.flow_id = '0;
                    exp.status  = ST_FULL;
                end else begin
                    slots[used_slots] = r;
                    exp.flow_id       = FLOW_ID_W'(used_slots);
                    exp.status        = ST_NEW;
                    used_slots++;
                end
            end
            awaited.push_back(exp);
        endfunction

        function void check_response(t_resp got);
            t_resp exp;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected word: flow_id %0d status %0d",
                             $time, got.flow_id, got.status);
                return;
            end
            exp = awaited.pop_front();
            if (got.flow_id !== exp.flow_id || got.status !== exp.status) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch: expected flow_id %0d status %s, got %0d %0d",
                             $time, exp.flow_id, exp.status.name(), got.flow_id, got.status);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_req                  i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_resp                 o_out_data;
    logic                  i_cfg_we = 1'b0;
    logic [ID_LIMIT_W-1:0] i_cfg_wdata = '0;

    flow_table_tracker table_tracker;
    t_req              key_pool[$];
    int unsigned       burst_left = 0;
    bit                long_stall_req = 1'b0;

    flow_tuple_id_table_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Both handshakes are sampled here, before the drivers' updates of this edge land.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                table_tracker.check_response(o_out_data);
            if (i_in_valid && o_in_ready)
                table_tracker.note_request(i_in_data);
        end
    end

    // Receiver: changing stall patterns, and a long hold-off when asked for one.
    initial begin
        int unsigned stall_left = 0;
        int unsigned mode_left = 0;
        int unsigned mode = 0;
        forever begin
            @(posedge i_clk);
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                stall_left     = 400;
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(4, 80);
                end
                mode_left--;
                case (mode)
                    0: begin
                        i_out_ready <= 1'b1;
                    end
                    1: begin
                        i_out_ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        i_out_ready <= ($urandom_range(0, 7) == 0);
                    end
                    default: begin
                        i_out_ready <= ~i_out_ready;
                    end
                endcase
            end
        end
    end

    function automatic t_req fresh_key();
        t_req k;
        k.src_family = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 30))
                                                   : 16'($urandom_range(1, 65535));
        k.dst_family = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 30))
                                                   : 16'($urandom_range(1, 65535));
        if ($urandom_range(0, 1) == 0) begin
            k.src_addr_hi = '0;
            k.src_addr_lo = {32'h0, $urandom};
            k.dst_addr_hi = '0;
            k.dst_addr_lo = {32'h0, $urandom};
        end else begin
            k.src_addr_hi = {$urandom, $urandom};
            k.src_addr_lo = {$urandom, $urandom};
            k.dst_addr_hi = {$urandom, $urandom};
            k.dst_addr_lo = {$urandom, $urandom};
        end
        k.src_port = 16'($urandom);
        k.dst_port = 16'($urandom);
        k.protocol = 8'($urandom);
        return k;
    endfunction

    function automatic t_req empty_key();
        t_req k;
        k = fresh_key();
        case ($urandom_range(0, 2))
            0: k.src_family = '0;
            1: k.dst_family = '0;
            default: begin
                k.src_family = '0;
                k.dst_family = '0;
            end
        endcase
        return k;
    endfunction

    function automatic void remember(t_req k);
        if (k.src_family == 16'd0 || k.dst_family == 16'd0)
            return;
        if (key_pool.size() < 256)
            key_pool.push_back(k);
        else
            key_pool[$urandom_range(0, 255)] = k;
    endfunction

    // Called at a clock edge; returns at the edge where the word is accepted.
    task automatic send_key(t_req k);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= k;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (table_tracker.awaited.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_id_limit(int unsigned v);
        pause_until_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v[ID_LIMIT_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        table_tracker.set_limit(v);
    endtask

    task automatic run_random_phase(int unsigned items);
        t_req        k;
        int unsigned pick;
        int unsigned flip;
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 78 && key_pool.size() != 0) begin
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end else if (pick < 88 && key_pool.size() != 0) begin
                // Near miss: a known key with a single bit turned over.
                k       = key_pool[$urandom_range(0, key_pool.size() - 1)];
                flip    = $urandom_range(0, $bits(t_req) - 1);
                k[flip] = ~k[flip];
            end else if (pick < 95) begin
                k = fresh_key();
            end else begin
                k = empty_key();
            end
            remember(k);
            send_key(k);
            if ($urandom_range(0, 59) == 0)
                pause_until_drained();
        end
    endtask

    initial begin
        t_req key_a;
        t_req key_b;
        t_req key_e;
        t_req key_f;
        t_req k;
        table_tracker = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        key_a = fresh_key();
        key_b = fresh_key();

        // With a zero limit every new key is refused.
        write_id_limit(0);
        send_key(key_a);
        send_key(empty_key());

        // A single slot: the first key takes it, a repeat of it hits, and the next new key is refused.
        write_id_limit(1);
        send_key(key_a);
        send_key(key_a);
        send_key(key_b);
        send_key(empty_key());

        // A limit above the depth behaves as the depth.
        write_id_limit(127);
        send_key(key_b);
        k = '1;
        send_key(k);
        k            = '0;
        k.src_family = 16'd1;
        k.dst_family = 16'd1;
        send_key(k);
        k = '1;
        send_key(k);
        k.protocol = 8'hFE;
        send_key(k);
        // Empty addresses never match, even themselves.
        key_e            = fresh_key();
        key_e.src_family = '0;
        send_key(key_e);
        send_key(key_e);
        key_f            = fresh_key();
        key_f.dst_family = '0;
        send_key(key_f);
        send_key(key_f);
        send_key(key_a);
        k             = key_a;
        k.src_family  = key_a.dst_family;
        k.dst_family  = key_a.src_family;
        k.src_addr_hi = key_a.dst_addr_hi;
        k.src_addr_lo = key_a.dst_addr_lo;
        k.dst_addr_hi = key_a.src_addr_hi;
        k.dst_addr_lo = key_a.src_addr_lo;
        k.src_port    = key_a.dst_port;
        k.dst_port    = key_a.src_port;
        send_key(k);
        remember(key_a);
        remember(key_b);
        remember(k);

        write_id_limit(64);
        run_random_phase(125);

        // Lowered below the fill level: old keys still hit, new ones are refused.
        write_id_limit(table_tracker.used_slots / 2);
        long_stall_req = 1'b1;
        burst_left     = 40;
        run_random_phase(125);

        write_id_limit(127);
        run_random_phase(125);
        write_id_limit(1);
        run_random_phase(125);
        write_id_limit(64);
        run_random_phase(125);
        write_id_limit($urandom_range(0, 127));
        run_random_phase(125);
        write_id_limit(127);
        run_random_phase(125);
        write_id_limit(0);
        run_random_phase(125);

        pause_until_drained();
        repeat (100) @(posedge i_clk);
        if (table_tracker.failures == 0 && table_tracker.awaited.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/ftid_pkg.sv
design/ftid_ram.sv
design/ftid_front.sv
design/ftid_queue.sv
design/ftid_back.sv
design/flow_tuple_id_table_unit.sv
design/ftid_checker.sv
test/tb_flow_tuple_id_table_unit.sv
